// ===== hw/rtl/mcs_pkg.sv =====
// Shared types, codes and constants of the multipath credit scheduler.
package mcs_pkg;

  // Command codes
  localparam logic [1:0] CMD_PICK  = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_REDUN = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PATH = 2'd1;
  localparam logic [1:0] ST_BAD_ARG = 2'd2;

  // Register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_PATH_COUNT = 3'd0;
  localparam logic [2:0] REG_ENABLED    = 3'd1;
  localparam logic [2:0] REG_WEIGHTS    = 3'd2;
  localparam logic [2:0] REG_BASE_RED   = 3'd3;
  localparam logic [2:0] REG_LOSS_THR   = 3'd4;
  localparam logic [2:0] REG_ALPHA      = 3'd5;

  // Arithmetic constants
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [16:0] ALPHA_DEFAULT = 17'd13107;
  localparam logic [9:0]  RED_MAX       = 10'd768;
  localparam logic [23:0] RTT_RESET     = 24'd5000;
  localparam logic [3:0]  DIV_STEPS     = 4'd14;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  path_index;
    logic [23:0] rtt_us;
    logic        probe_received;
    logic [7:0]  k;
  } mcs_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chosen_path;
    logic [7:0]  n_blocks;
    logic [23:0] rtt_estimate_us;
    logic [16:0] loss_estimate;
    logic        path_is_alive;
    logic [31:0] sent_count;
    logic [31:0] received_count;
  } mcs_rsp_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_PICK_CHK,
    SQ_PICK_SEL,
    SQ_PICK_DEC,
    SQ_PRB_RTT_A,
    SQ_PRB_RTT_B,
    SQ_PRB_LOSS_A,
    SQ_PRB_LOSS_B,
    SQ_PRB_UPD,
    SQ_RED_CNT,
    SQ_RED_MUL_A,
    SQ_RED_MUL_B,
    SQ_RED_SCALE,
    SQ_RED_DIV,
    SQ_RED_FIN,
    SQ_DONE
  } mcs_state_t;

endpackage

// ===== hw/rtl/mcs_ifs.sv =====
// Request and response channel interfaces of the multipath credit scheduler.
interface mcs_req_if import mcs_pkg::*; ();
  logic     valid;
  logic     ready;
  mcs_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcs_rsp_if import mcs_pkg::*; ();
  logic     valid;
  logic     ready;
  mcs_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mcs_mul.sv =====
// Shared registered 17 x 24 multiplier of the scheduler datapath.
module mcs_mul (
  input  logic        clk,
  input  logic [16:0] a,
  input  logic [23:0] b,
  output logic [40:0] p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= {24'b0, a} * {17'b0, b};
  end

endmodule

// ===== hw/rtl/multipath_credit_scheduler.sv =====
// Top level: multipath credit scheduler with smoothed path health.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+-------------------------------------
//  req     | in  | valid/ready        | cmd, path_index, rtt_us, probe, k
//  rsp     | out | valid/ready        | status, path, n, rtt, loss, counters
//  apb     | in  | psel/penable/pwrite| six registers at byte address 8*i
//
// Steps: a pick makes two scans over the paths, or one when no path is
// eligible; a probe makes four passes through the shared multiplier; a
// redundancy command counts the paths, multiplies, scales and, when some
// but not all enabled paths are alive and the ratio stays under its cap,
// runs the serial divider. Bad arguments finish without further steps.
// Reset is synchronous and restores configuration, sequencer and path state at once.
// A result waits in the output register; the next transaction is taken
// meanwhile, and only the final step of the next item waits for it.
module multipath_credit_scheduler import mcs_pkg::*; #(
  parameter int NUM_PATHS  = 8,
  parameter int MAX_BLOCKS = 255
) (
  input  logic        clk,
  input  logic        rst,
  mcs_req_if.sink     req,
  mcs_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int PW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam logic [PW-1:0] LAST_PATH = PW'(NUM_PATHS - 1);

  // Configuration registers
  logic [3:0]  paths_used;
  logic [7:0]  enabled_mask;
  logic [63:0] path_weights;
  logic [9:0]  red_ratio;
  logic [16:0] loss_limit;
  logic [16:0] smooth_gain;
  logic        reload_pend;

  // Per-path state
  logic [7:0]  credit          [NUM_PATHS];
  logic        path_alive      [NUM_PATHS];
  logic [23:0] smoothed_rtt    [NUM_PATHS];
  logic [16:0] smoothed_loss   [NUM_PATHS];
  logic [31:0] probe_tx        [NUM_PATHS];
  logic [31:0] probes_received [NUM_PATHS];

  // Sequencer and working registers
  mcs_state_t  state, state_next;
  mcs_req_t    cur;
  mcs_rsp_t    res;
  mcs_rsp_t    res_start;
  mcs_rsp_t    out_data;
  logic        out_valid;
  logic [PW-1:0] scan_idx;
  logic [PW-1:0] pidx;
  logic        any_elig;
  logic        all_zero;
  logic        best_valid;
  logic [PW-1:0] best_idx;
  logic [7:0]  best_credit;
  logic [41:0] acc;
  logic [23:0] rtt_new;
  logic [4:0]  tot_cnt;
  logic [4:0]  alv_cnt;
  logic        div_one;
  logic [13:0] div_quo;
  logic [3:0]  div_rem;
  logic [3:0]  div_cnt;

  // Multiplier operands and product
  logic [16:0] mul_a;
  logic [23:0] mul_b;
  logic [40:0] prod;

  logic [4:0]  eff_count;
  logic [16:0] one_minus_alpha;
  logic [41:0] ewma_sum;
  logic        cfg_wr;
  logic        accept;
  logic        out_free;
  logic        scan_last;
  logic        scan_in_range;
  logic        scan_elig;
  logic [7:0]  scan_refill;
  logic [7:0]  scan_cand;
  logic [16:0] loss_new;
  logic        alive_new;
  logic [14:0] alv_x768;
  logic [16:0] red_factor;
  logic [13:0] scaled_q;
  logic [4:0]  div_shift;
  logic [14:0] quo_ceil;
  logic [16:0] n_raised;
  logic [16:0] n_final;
  logic [3:0]  best4;

  function automatic logic [7:0] weight_of(input logic [3:0] i, input logic [63:0] w);
    logic [7:0] r;
    r = 8'd0;
    if (i < 4'd8) r = w[{i[2:0], 3'b000} +: 8];
    return r;
  endfunction

  function automatic logic [7:0] refill_of(input logic [3:0] i, input logic [63:0] w);
    logic [7:0] r;
    r = weight_of(i, w);
    if (r == 8'd0) r = 8'd1;
    return r;
  endfunction

  function automatic logic enabled_of(input logic [3:0] i, input logic [7:0] m);
    return (i < 4'd8) && m[i[2:0]];
  endfunction

  mcs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Derived values
  assign eff_count = (5'(paths_used) > 5'(NUM_PATHS)) ? 5'(NUM_PATHS) : 5'(paths_used);
  assign one_minus_alpha = 17'(18'(ONE_Q16) - 18'(smooth_gain));
  assign ewma_sum  = acc + 42'(prod) + 42'd32768;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign scan_last = (scan_idx == LAST_PATH);
  assign scan_in_range = 5'(scan_idx) < eff_count;
  assign scan_elig = scan_in_range && enabled_of(4'(scan_idx), enabled_mask)
                     && path_alive[scan_idx];
  assign scan_refill = refill_of(4'(scan_idx), path_weights);
  assign scan_cand = all_zero ? scan_refill : credit[scan_idx];
  assign loss_new  = ewma_sum[32:16];
  assign alv_x768  = {alv_cnt, 10'b0} - {2'b0, alv_cnt, 8'b0};
  assign scaled_q  = 14'((prod[21:0] + 22'd255) >> 8);
  assign div_shift = {div_rem, div_quo[13]};
  assign quo_ceil  = {1'b0, div_quo} + 15'(div_rem != 4'd0);
  assign n_raised  = (17'(quo_ceil) < 17'(cur.k)) ? 17'(cur.k) : 17'(quo_ceil);
  assign n_final   = (n_raised > 17'(MAX_BLOCKS)) ? 17'(MAX_BLOCKS) : n_raised;
  assign best4     = 4'(best_idx);

  // Start the result of an accepted request with its argument check
  always_comb begin
    res_start = '0;
    case (req.data.cmd)
      CMD_PICK:  res_start.status = ST_OK;
      CMD_PROBE: begin
        if ({2'b0, req.data.path_index} >= eff_count) res_start.status = ST_BAD_ARG;
      end
      CMD_REDUN: begin
        if (req.data.k == 8'd0) res_start.status = ST_BAD_ARG;
      end
      default:   res_start.status = ST_BAD_ARG;
    endcase
  end

  // Hysteresis on the alive flag
  always_comb begin
    alive_new = path_alive[pidx];
    if (loss_new > loss_limit) alive_new = 1'b0;
    if ({1'b0, loss_new} << 1 < {1'b0, loss_limit}) alive_new = 1'b1;
  end

  // Ratio factor for the redundancy multiply
  always_comb begin
    if (alv_cnt == 5'd0 || (alv_cnt != tot_cnt && 15'(prod) > alv_x768)) begin
      red_factor = 17'(RED_MAX);
    end else if (alv_cnt == tot_cnt) begin
      red_factor = 17'(red_ratio);
    end else begin
      red_factor = prod[16:0];
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_a = 17'd0;
    mul_b = 24'd0;
    case (state)
      SQ_PRB_RTT_A: begin
        mul_a = smooth_gain;
        mul_b = cur.rtt_us;
      end
      SQ_PRB_RTT_B: begin
        mul_a = one_minus_alpha;
        mul_b = smoothed_rtt[pidx];
      end
      SQ_PRB_LOSS_A: begin
        mul_a = smooth_gain;
        mul_b = cur.probe_received ? 24'd0 : 24'(ONE_Q16);
      end
      SQ_PRB_LOSS_B: begin
        mul_a = one_minus_alpha;
        mul_b = 24'(smoothed_loss[pidx]);
      end
      SQ_RED_MUL_A: begin
        mul_a = 17'(red_ratio);
        mul_b = 24'(tot_cnt);
      end
      SQ_RED_MUL_B: begin
        mul_a = red_factor;
        mul_b = 24'(cur.k);
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 24'd0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (accept) begin
          case (req.data.cmd)
            CMD_PICK:  state_next = SQ_PICK_CHK;
            CMD_PROBE: state_next = ({2'b0, req.data.path_index} < eff_count) ?
                                    SQ_PRB_RTT_A : SQ_DONE;
            CMD_REDUN: state_next = (req.data.k != 8'd0) ? SQ_RED_CNT : SQ_DONE;
            default:   state_next = SQ_DONE;
          endcase
        end
      end
      SQ_PICK_CHK:   if (scan_last) state_next = (any_elig || scan_elig) ?
                                                 SQ_PICK_SEL : SQ_DONE;
      SQ_PICK_SEL:   if (scan_last) state_next = SQ_PICK_DEC;
      SQ_PICK_DEC:   state_next = SQ_DONE;
      SQ_PRB_RTT_A:  state_next = SQ_PRB_RTT_B;
      SQ_PRB_RTT_B:  state_next = SQ_PRB_LOSS_A;
      SQ_PRB_LOSS_A: state_next = SQ_PRB_LOSS_B;
      SQ_PRB_LOSS_B: state_next = SQ_PRB_UPD;
      SQ_PRB_UPD:    state_next = SQ_DONE;
      SQ_RED_CNT:    if (scan_last) state_next = SQ_RED_MUL_A;
      SQ_RED_MUL_A:  state_next = SQ_RED_MUL_B;
      SQ_RED_MUL_B:  state_next = SQ_RED_SCALE;
      SQ_RED_SCALE:  state_next = div_one ? SQ_RED_FIN : SQ_RED_DIV;
      SQ_RED_DIV:    if (div_cnt == DIV_STEPS - 4'd1) state_next = SQ_RED_FIN;
      SQ_RED_FIN:    state_next = SQ_DONE;
      SQ_DONE:       if (out_free) state_next = SQ_IDLE;
      default:       state_next = SQ_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req.ready = (state == SQ_IDLE) && !reload_pend;
    rsp.valid = out_valid;
    rsp.data  = out_data;
  end

  // Register read
  always_comb begin
    case (paddr[5:3])
      REG_PATH_COUNT: prdata = 64'(paths_used);
      REG_ENABLED:    prdata = 64'(enabled_mask);
      REG_WEIGHTS:    prdata = path_weights;
      REG_BASE_RED:   prdata = 64'(red_ratio);
      REG_LOSS_THR:   prdata = 64'(loss_limit);
      REG_ALPHA:      prdata = 64'(smooth_gain);
      default:        prdata = 64'd0;
    endcase
  end

  // Configuration registers; every valid write schedules a reload
  always_ff @(posedge clk) begin
    if (rst) begin
      paths_used      <= 4'd1;
      enabled_mask    <= 8'hFF;
      path_weights    <= 64'h0101010101010101;
      red_ratio       <= 10'd256;
      loss_limit      <= 17'd6554;
      smooth_gain     <= ALPHA_DEFAULT;
      reload_pend     <= 1'b0;
    end else begin
      reload_pend <= cfg_wr && (paddr[5:3] inside {REG_PATH_COUNT, REG_ENABLED,
                     REG_WEIGHTS, REG_BASE_RED, REG_LOSS_THR, REG_ALPHA});
      if (cfg_wr) begin
        case (paddr[5:3])
          REG_PATH_COUNT: paths_used      <= pwdata[3:0];
          REG_ENABLED:    enabled_mask    <= pwdata[7:0];
          REG_WEIGHTS:    path_weights    <= pwdata;
          REG_BASE_RED:   red_ratio       <= pwdata[9:0];
          REG_LOSS_THR:   loss_limit      <= pwdata[16:0];
          REG_ALPHA: begin
            if (pwdata[16:0] == 17'd0) smooth_gain <= ALPHA_DEFAULT;
            else if (pwdata[16:0] > ONE_Q16) smooth_gain <= ONE_Q16;
            else smooth_gain <= pwdata[16:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == SQ_DONE && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_DONE && out_free) out_data <= res;
  end

  // Working registers and per-path state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        credit[i]          <= 8'd1;
        path_alive[i]      <= (i < 8);
        smoothed_rtt[i]    <= RTT_RESET;
        smoothed_loss[i]   <= 17'd0;
        probe_tx[i]        <= 32'd0;
        probes_received[i] <= 32'd0;
      end
    end else begin
      // Apply the reload rule after a register write
      if (reload_pend) begin
        for (int i = 0; i < NUM_PATHS; i++) begin
          if (5'(i) < eff_count) begin
            if (!enabled_of(4'(i), enabled_mask)) path_alive[i] <= 1'b0;
            else credit[i] <= refill_of(4'(i), path_weights);
          end
        end
      end
      case (state)
        SQ_IDLE: begin
          if (accept) begin
            cur        <= req.data;
            pidx       <= PW'({1'b0, req.data.path_index});
            res        <= res_start;
            scan_idx   <= '0;
            any_elig   <= 1'b0;
            all_zero   <= 1'b1;
            best_valid <= 1'b0;
            tot_cnt    <= 5'd0;
            alv_cnt    <= 5'd0;
          end
        end
        // Look for eligible paths and any nonzero credit
        SQ_PICK_CHK: begin
          if (scan_elig) begin
            any_elig <= 1'b1;
            if (credit[scan_idx] != 8'd0) all_zero <= 1'b0;
          end
          scan_idx <= scan_last ? '0 : scan_idx + 1'b1;
          if (scan_last && !(any_elig || scan_elig)) res.status <= ST_NO_PATH;
        end
        // Refill if needed and track the highest credit
        SQ_PICK_SEL: begin
          if (scan_elig) begin
            if (all_zero) credit[scan_idx] <= scan_refill;
            if (!best_valid || scan_cand > best_credit) begin
              best_valid  <= 1'b1;
              best_idx    <= scan_idx;
              best_credit <= scan_cand;
            end
          end
          scan_idx <= scan_last ? '0 : scan_idx + 1'b1;
        end
        SQ_PICK_DEC: begin
          if (best_credit != 8'd0) credit[best_idx] <= best_credit - 8'd1;
          res.chosen_path <= best4[2:0];
        end
        SQ_PRB_RTT_B: acc <= 42'(prod);
        SQ_PRB_LOSS_A: rtt_new <= cur.probe_received ? ewma_sum[39:16] : smoothed_rtt[pidx];
        SQ_PRB_LOSS_B: acc <= 42'(prod);
        // Commit the probe update
        SQ_PRB_UPD: begin
          probe_tx[pidx]      <= probe_tx[pidx] + 32'd1;
          smoothed_rtt[pidx]  <= rtt_new;
          smoothed_loss[pidx] <= loss_new;
          path_alive[pidx]    <= alive_new;
          if (cur.probe_received) probes_received[pidx] <= probes_received[pidx] + 32'd1;
          res.rtt_estimate_us <= rtt_new;
          res.loss_estimate   <= loss_new;
          res.path_is_alive   <= alive_new;
          res.sent_count      <= probe_tx[pidx] + 32'd1;
          res.received_count  <= probes_received[pidx] + 32'(cur.probe_received);
        end
        // Count enabled and alive paths
        SQ_RED_CNT: begin
          if (scan_in_range && enabled_of(4'(scan_idx), enabled_mask)) begin
            tot_cnt <= tot_cnt + 5'd1;
            if (path_alive[scan_idx]) alv_cnt <= alv_cnt + 5'd1;
          end
          scan_idx <= scan_last ? '0 : scan_idx + 1'b1;
        end
        SQ_RED_MUL_B: begin
          div_one <= (alv_cnt == 5'd0) || (alv_cnt == tot_cnt) || (15'(prod) > alv_x768);
        end
        SQ_RED_SCALE: begin
          div_quo <= scaled_q;
          div_rem <= 4'd0;
          div_cnt <= 4'd0;
        end
        // One quotient bit per cycle
        SQ_RED_DIV: begin
          if (div_shift >= alv_cnt) begin
            div_rem <= 4'(div_shift - alv_cnt);
            div_quo <= {div_quo[12:0], 1'b1};
          end else begin
            div_rem <= div_shift[3:0];
            div_quo <= {div_quo[12:0], 1'b0};
          end
          div_cnt <= div_cnt + 4'd1;
        end
        SQ_RED_FIN: res.n_blocks <= n_final[7:0];
        default: begin
        end
      endcase
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    (state != SQ_IDLE) |-> !req.ready)
    else $error("request taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    (smooth_gain != 17'd0) && (smooth_gain <= ONE_Q16))
    else $error("smoothing factor out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == SQ_RED_DIV) |-> (div_cnt < DIV_STEPS) && (alv_cnt != 5'd0))
    else $error("divider overrun");

  assert property (@(posedge clk) disable iff (rst)
    (state == SQ_PICK_DEC) |-> best_valid && (best_credit != 8'd0))
    else $error("pick without a credited path");

endmodule

// ===== test/tb_scoreboard.sv =====
// Result predictor and checker for the multipath credit scheduler testbench.
`timescale 1ns / 100ps

import mcs_pkg::*;

class mcs_scoreboard;

  // mirrored configuration
  logic [3:0]  paths_used;
  logic [7:0]  enabled_mask;
  logic [63:0] path_weights;
  logic [9:0]  base_red;
  logic [16:0] loss_thr;
  logic [16:0] alpha;

  // mirrored path state
  logic [7:0]  credit[8];
  logic        alive[8];
  logic [23:0] srtt[8];
  logic [16:0] sloss[8];
  logic [31:0] sent[8];
  logic [31:0] rcvd[8];

  mcs_rsp_t pending_rsp[$];
  int mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    paths_used = 4'd1;
    enabled_mask = 8'hFF;
    path_weights = 64'h0101010101010101;
    base_red = 10'd256;
    loss_thr = 17'd6554;
    alpha = ALPHA_DEFAULT;
    for (int i = 0; i < 8; i++) begin
      credit[i] = 8'd1;
      alive[i] = 1'b1;
      srtt[i] = RTT_RESET;
      sloss[i] = '0;
      sent[i] = '0;
      rcvd[i] = '0;
    end
    pending_rsp.delete();
  endfunction

  function int active_paths();
    return (paths_used > 8) ? 8 : int'(paths_used);
  endfunction

  function logic [7:0] refill_of(int i);
    logic [7:0] w;
    w = path_weights[8*i +: 8];
    return (w == 0) ? 8'd1 : w;
  endfunction

  function bit eligible(int i);
    return i < active_paths() && enabled_mask[i] && alive[i];
  endfunction

  function logic [63:0] smooth(logic [63:0] sample, logic [63:0] old);
    return (64'(alpha) * sample + (64'(ONE_Q16) - 64'(alpha)) * old + 64'd32768) >> 16;
  endfunction

  // apply a register write and the reload rule
  function void write_reg(logic [2:0] idx, logic [63:0] value);
    logic [16:0] a;
    case (idx)
      REG_PATH_COUNT: paths_used = value[3:0];
      REG_ENABLED:    enabled_mask = value[7:0];
      REG_WEIGHTS:    path_weights = value;
      REG_BASE_RED:   base_red = value[9:0];
      REG_LOSS_THR:   loss_thr = value[16:0];
      REG_ALPHA: begin
        a = value[16:0];
        if (a == 0) a = ALPHA_DEFAULT;
        if (a > ONE_Q16) a = ONE_Q16;
        alpha = a;
      end
      default: return;
    endcase
    for (int i = 0; i < active_paths(); i++) begin
      if (!enabled_mask[i]) alive[i] = 1'b0;
      else credit[i] = refill_of(i);
    end
  endfunction

  // compute the expected response of one accepted request
  function void note_request(mcs_req_t rq);
    mcs_rsp_t r;
    int pc, best;
    bit any, refill;
    logic [63:0] loss, tot, liv, num, den, n;
    r = '0;
    pc = active_paths();
    case (rq.cmd)
      CMD_PICK: begin
        any = 0;
        refill = 1;
        best = -1;
        for (int i = 0; i < pc; i++)
          if (eligible(i)) begin
            any = 1;
            if (credit[i] > 0) refill = 0;
          end
        if (!any) r.status = ST_NO_PATH;
        else begin
          if (refill)
            for (int i = 0; i < pc; i++) if (eligible(i)) credit[i] = refill_of(i);
          for (int i = 0; i < pc; i++)
            if (eligible(i) && (best < 0 || credit[i] > credit[best])) best = i;
          if (credit[best] > 0) credit[best]--;
          r.chosen_path = best[2:0];
        end
      end
      CMD_PROBE: begin
        if (rq.path_index >= pc) r.status = ST_BAD_ARG;
        else begin
          best = rq.path_index;
          sent[best]++;
          if (rq.probe_received) begin
            rcvd[best]++;
            srtt[best] = 24'(smooth(64'(rq.rtt_us), 64'(srtt[best])));
          end
          loss = smooth(rq.probe_received ? 64'd0 : 64'd65536, 64'(sloss[best]));
          sloss[best] = loss[16:0];
          if (sloss[best] > loss_thr) alive[best] = 1'b0;
          if (18'(sloss[best]) * 2 < 18'(loss_thr)) alive[best] = 1'b1;
          r.rtt_estimate_us = srtt[best];
          r.loss_estimate = sloss[best];
          r.path_is_alive = alive[best];
          r.sent_count = sent[best];
          r.received_count = rcvd[best];
        end
      end
      CMD_REDUN: begin
        if (rq.k == 0) r.status = ST_BAD_ARG;
        else begin
          tot = 0;
          liv = 0;
          for (int i = 0; i < pc; i++)
            if (enabled_mask[i]) begin
              tot++;
              if (alive[i]) liv++;
            end
          den = 256;
          if (liv == 0) num = rq.k * 64'(RED_MAX);
          else if (liv < tot) begin
            if (64'(base_red) * tot > 64'(RED_MAX) * liv) num = rq.k * 64'(RED_MAX);
            else begin
              num = rq.k * 64'(base_red) * tot;
              den = 256 * liv;
            end
          end else num = rq.k * 64'(base_red);
          n = (num + den - 1) / den;
          if (n < rq.k) n = rq.k;
          if (n > 255) n = 255;
          r.n_blocks = n[7:0];
        end
      end
      default: r.status = ST_BAD_ARG;
    endcase
    pending_rsp.push_back(r);
  endfunction

  function void report(string what, logic [63:0] e, logic [63:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d actual %0d", what, e, a);
  endfunction

  // compare one accepted response against the oldest expectation
  function void check_response(mcs_rsp_t a);
    mcs_rsp_t e;
    if (pending_rsp.size() == 0) begin
      report("unexpected response", 0, 1);
      return;
    end
    e = pending_rsp.pop_front();
    if (a.status !== e.status) report("status", e.status, a.status);
    if (a.chosen_path !== e.chosen_path) report("chosen_path", e.chosen_path, a.chosen_path);
    if (a.n_blocks !== e.n_blocks) report("n_blocks", e.n_blocks, a.n_blocks);
    if (a.rtt_estimate_us !== e.rtt_estimate_us)
      report("rtt_estimate_us", e.rtt_estimate_us, a.rtt_estimate_us);
    if (a.loss_estimate !== e.loss_estimate)
      report("loss_estimate", e.loss_estimate, a.loss_estimate);
    if (a.path_is_alive !== e.path_is_alive)
      report("path_is_alive", e.path_is_alive, a.path_is_alive);
    if (a.sent_count !== e.sent_count) report("sent_count", e.sent_count, a.sent_count);
    if (a.received_count !== e.received_count)
      report("received_count", e.received_count, a.received_count);
  endfunction
endclass

// ===== test/tb.sv =====
// Top of the multipath credit scheduler testbench: stimulus, response sink, watchdog.
`timescale 1ns / 100ps

module tb import mcs_pkg::*; ;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  logic stim_done;
  int idle_cycles;
  int sink_mode;

  mcs_req_if req_ch ();
  mcs_rsp_if rsp_ch ();
  mcs_scoreboard sb;

  multipath_credit_scheduler dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle(int n);
    repeat (n) @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.write_reg(idx, value);
  endtask

  // hold the request until accepted
  task automatic send(mcs_req_t rq, bit gaps);
    if (gaps) idle(gap_len());
    req_ch.valid = 1'b1;
    req_ch.data = rq;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(rq);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    idle(40);
  endtask

  function mcs_req_t make_req(logic [1:0] c, logic [2:0] p, logic [23:0] t, logic rv,
                              logic [7:0] kk);
    mcs_req_t rq;
    rq.cmd = c; rq.path_index = p; rq.rtt_us = t; rq.probe_received = rv; rq.k = kk;
    return rq;
  endfunction

  function mcs_req_t rand_req();
    int r;
    logic [1:0] c;
    r = $urandom_range(0, 99);
    if (r < 40) c = CMD_PICK;
    else if (r < 75) c = CMD_PROBE;
    else if (r < 97) c = CMD_REDUN;
    else c = 2'd3;
    return make_req(c, 3'($urandom_range(0, 7)),
      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000)),
      ($urandom_range(0, 3) != 0), 8'($urandom_range(0, 255)));
  endfunction

  // random configuration with occasional extremes
  task automatic random_config();
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) w = 64'h0;
    write_reg(REG_PATH_COUNT, 64'($urandom_range(0, 15)));
    write_reg(REG_ENABLED, 64'($urandom_range(0, 255)));
    write_reg(REG_WEIGHTS, ($urandom_range(0, 1) != 0) ? (w & 64'h0707070707070707) : w);
    write_reg(REG_BASE_RED, 64'($urandom_range(0, 1023)));
    write_reg(REG_LOSS_THR, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 131071))
                                                         : 64'($urandom_range(2000, 40000)));
    write_reg(REG_ALPHA, ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 131071))
                                                      : 64'($urandom_range(5000, 40000)));
  endtask

  // response side: random stalls, with stall-free stretches
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) sink_mode <= $urandom_range(0, 2);
      if (sink_mode == 0) rsp_ch.ready <= 1'b1;
      else if (sink_mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= ($urandom_range(0, 19) == 0);
    end
  end

  // check responses and watch for stalls
  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
        idle_cycles <= 0;
      else if (!stim_done || sb.pending_rsp.size() != 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL multipath_credit_scheduler");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    stim_done = 1'b0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset state, extremes, every command and special case
    send(make_req(CMD_PICK, 0, 0, 0, 0), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd0), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd255), 0);
    send(make_req(CMD_PROBE, 3'd7, 24'hFFFFFF, 1, 8'hFF), 0);
    send(make_req(2'd3, 0, 0, 0, 0), 0);
    drain();
    write_reg(REG_PATH_COUNT, 64'd8);
    write_reg(REG_ENABLED, 64'hFF);
    write_reg(REG_WEIGHTS, 64'h00FF030201000402);
    write_reg(REG_ALPHA, 64'd65536);
    write_reg(REG_LOSS_THR, 64'd65536);
    write_reg(REG_BASE_RED, 64'd768);
    for (int i = 0; i < 6; i++) send(make_req(CMD_PICK, 0, 0, 0, 0), 0);
    send(make_req(CMD_PROBE, 3'd7, 24'hFFFFFF, 1, 0), 0);
    send(make_req(CMD_PROBE, 3'd2, 24'd0, 0, 0), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd1), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd200), 0);
    drain();
    write_reg(REG_LOSS_THR, 64'd0);
    write_reg(REG_ALPHA, 64'd0);
    send(make_req(CMD_PROBE, 3'd1, 24'd100, 0, 0), 0);
    send(make_req(CMD_PROBE, 3'd3, 24'd100, 0, 0), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd100), 0);
    drain();
    write_reg(REG_PATH_COUNT, 64'd15);
    write_reg(REG_ENABLED, 64'h00);
    send(make_req(CMD_PICK, 0, 0, 0, 0), 0);
    send(make_req(CMD_REDUN, 0, 0, 0, 8'd10), 0);
    drain();
    write_reg(REG_ALPHA, 64'h1FFFF);
    write_reg(REG_PATH_COUNT, 64'd0);
    send(make_req(CMD_PICK, 0, 0, 0, 0), 0);
    send(make_req(CMD_PROBE, 0, 24'd5, 1, 0), 0);

    // random phases, each with a fresh configuration
    for (int ph = 0; ph < 25; ph++) begin
      drain();
      random_config();
      for (int j = 0; j < 50; j++) begin
        send(rand_req(), 1);
        if (ph == 3 && j == 25) while (sb.pending_rsp.size() != 0) @(negedge clk);
      end
    end

    stim_done = 1'b1;
    drain();
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
      $display("PASS multipath_credit_scheduler");
    else
      $display("FAIL multipath_credit_scheduler");
    $finish;
  end
endmodule
